// ===== src/lut3d_pkg.sv =====
// Shared constants, types and the fixed-point lerp for the 3D LUT color map.
// Used by all block modules but lut3d_ram, lut3d_checker; depends on nothing.
`default_nettype none
package lut3d_pkg;

  localparam int MAX_SIZE    = 33;
  localparam int TABLE_DEPTH = MAX_SIZE * MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CH_W        = 17;            // stored channel, 0..65536
  localparam int IO_W        = 18;            // port channel, signed
  localparam int ENTRY_W     = 3 * CH_W;
  localparam int SIZE_W      = 6;
  localparam int ONE_FX      = 65536;
  localparam int QDEPTH      = 16;            // result queue depth
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int CNT_W       = QPTR_W + 1;

  // transaction commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // sample context that travels with the corner reads
  typedef struct packed {
    logic                     pass;   // table size zero: forward raw input
    logic [2:0][IO_W-1:0]     raw;
    logic [2:0][15:0]         frac;
  } samp_t;

  // a + floor(((b - a) * t + 32768) / 65536), endpoints in 0..65536
  function automatic logic [CH_W-1:0] lerp_fx(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b,
                                               input logic [15:0]     t);
    logic signed [CH_W:0]   diff;
    logic signed [CH_W+17:0] prod;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, t}) + 35'sd32768;
    return CH_W'(a + prod[16+CH_W-1:16]);
  endfunction

endpackage
`default_nettype wire

// ===== src/lut3d_trilinear_color_map.sv =====
// Top level of the 3D LUT color map with trilinear interpolation.
// Uses lut3d_pkg, lut3d_front, lut3d_back, lut3d_fifo.
//
// Input channel: in_valid_i / in_stall_o, transaction fields cmd_i,
//   entry_index_i, red_in_i, green_in_i, blue_in_i. A write (cmd 0) stores one
//   entry, saturated to 0..1; a sample (cmd 1) yields one result.
// Output channel: out_valid_o / out_stall_i with red_out_o, green_out_o,
//   blue_out_o. Results leave in sample order.
// Config: cfg_we_i writes lut_size from cfg_data_i; do it only while idle.
// Throughput: one transaction per cycle while in_stall_o is low, writes and
//   samples mixed. The eight corners come from eight copies of the table, so
//   each cycle reads all corners at once; every write updates all copies.
// Path: a sample passes three front stages with the table read, two blend
//   stages and the queue write before it is offered on the output, behind any
//   older results still in the queue.
// Stall: a credit counter admits at most 16 samples that are not yet taken;
//   with the output stalled the queue fills and in_stall_o rises.
// Reset: clears pipeline valids, queue and lut_size (pass-through). Table
//   contents are undefined until written; no clearing pass.
`default_nettype none
module lut3d_trilinear_color_map
  import lut3d_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [SIZE_W-1:0]      cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   cmd_i,
  input  wire logic [15:0]            entry_index_i,
  input  wire logic signed [IO_W-1:0] red_in_i,
  input  wire logic signed [IO_W-1:0] green_in_i,
  input  wire logic signed [IO_W-1:0] blue_in_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [IO_W-1:0]      red_out_o,
  output logic signed [IO_W-1:0]      green_out_o,
  output logic signed [IO_W-1:0]      blue_out_o
);

  // config register
  logic [SIZE_W-1:0] lut_size_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lut_size_q <= '0;
    end else if (cfg_we_i) begin
      lut_size_q <= cfg_data_i;
    end
  end

  // credit count of samples not yet delivered
  logic             in_fire, out_fire;
  logic [CNT_W-1:0] credit_q, credit_d;

  assign in_stall_o = (credit_q == CNT_W'(QDEPTH));
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_o && !out_stall_i;

  always_comb begin
    credit_d = credit_q + CNT_W'(in_fire && (cmd_i == CMD_SAMPLE)) - CNT_W'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  // front end
  logic                     rd_valid;
  samp_t                    rd_ctx;
  logic [7:0][ENTRY_W-1:0]  corner;
  logic [2:0][IO_W-1:0]     chan_in;

  assign chan_in = {blue_in_i, green_in_i, red_in_i};

  lut3d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .cmd_i        (cmd_i),
    .entry_index_i(entry_index_i),
    .chan_i       (chan_in),
    .lut_size_i   (lut_size_q),
    .rd_valid_o   (rd_valid),
    .rd_ctx_o     (rd_ctx),
    .corner_o     (corner)
  );

  // back end
  logic                 res_valid;
  logic [2:0][IO_W-1:0] res;

  lut3d_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_valid_i (rd_valid),
    .rd_ctx_i   (rd_ctx),
    .corner_i   (corner),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // result queue
  logic [2:0][IO_W-1:0] out_data;

  lut3d_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .pop_i      (out_fire),
    .valid_o    (out_valid_o),
    .data_o     (out_data)
  );

  assign red_out_o   = out_data[0];
  assign green_out_o = out_data[1];
  assign blue_out_o  = out_data[2];

endmodule
`default_nettype wire

// ===== src/lut3d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none
module lut3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== src/lut3d_front.sv =====
// Front end: classifies transactions, computes grid positions and corner
// addresses, writes the table and reads the eight corners. Uses lut3d_pkg, lut3d_ram.
`default_nettype none
module lut3d_front
  import lut3d_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         fire_i,
  input  wire logic                         cmd_i,
  input  wire logic [ADDR_W-1:0]            entry_index_i,
  input  wire logic [2:0][IO_W-1:0]         chan_i,
  input  wire logic [SIZE_W-1:0]            lut_size_i,
  output logic                              rd_valid_o,
  output samp_t                             rd_ctx_o,
  output logic      [7:0][ENTRY_W-1:0]      corner_o
);

  // effective size
  logic [SIZE_W-1:0]   size;
  logic [SIZE_W-1:0]   size_m1;
  logic [2*SIZE_W-1:0] size_sq;
  assign size    = (lut_size_i > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : lut_size_i;
  assign size_m1 = size - SIZE_W'(1);
  assign size_sq = size * size;

  // stage 1: clamp and scale
  logic [2:0][CH_W-1:0]        clamp;
  logic [2:0][CH_W+SIZE_W-1:0] pos;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if ($signed(chan_i[k]) <= 0) begin
        clamp[k] = '0;
      end else if ($signed(chan_i[k]) >= 18'sd65536) begin
        clamp[k] = CH_W'(ONE_FX);
      end else begin
        clamp[k] = chan_i[k][CH_W-1:0];
      end
      pos[k] = clamp[k] * size_m1;
    end
  end

  logic                        s1_valid_q, s1_write_q, s1_pass_q;
  logic [ADDR_W-1:0]           s1_idx_q;
  logic [2:0][CH_W-1:0]        s1_data_q;
  logic [2:0][IO_W-1:0]        s1_raw_q;
  logic [2:0][CH_W+SIZE_W-1:0] s1_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_write_q <= (cmd_i == CMD_WRITE);
    s1_pass_q  <= (size == '0);
    s1_idx_q   <= entry_index_i;
    s1_data_q  <= clamp;
    s1_raw_q   <= chan_i;
    s1_pos_q   <= pos;
  end

  // stage 2: grid index, neighbor and axis address terms
  logic [2:0][SIZE_W-1:0] lo, hi;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo[k] = s1_pos_q[k][16 +: SIZE_W];
      hi[k] = ((lo[k] + SIZE_W'(1)) < size) ? lo[k] + SIZE_W'(1) : lo[k];
    end
  end

  logic                   s2_valid_q, s2_write_q;
  samp_t                  s2_ctx_q;
  logic [ADDR_W-1:0]      s2_idx_q;
  logic [ENTRY_W-1:0]     s2_data_q;
  logic [1:0][ADDR_W-1:0] s2_r_q, s2_g_q, s2_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_write_q    <= s1_write_q;
    s2_ctx_q.pass <= s1_pass_q;
    s2_ctx_q.raw  <= s1_raw_q;
    for (int k = 0; k < 3; k++) begin
      s2_ctx_q.frac[k] <= s1_pos_q[k][15:0];
    end
    s2_idx_q  <= s1_idx_q;
    s2_data_q <= {s1_data_q[2], s1_data_q[1], s1_data_q[0]};
    s2_r_q[0] <= ADDR_W'(lo[0]);
    s2_r_q[1] <= ADDR_W'(hi[0]);
    s2_g_q[0] <= ADDR_W'(lo[1] * size);
    s2_g_q[1] <= ADDR_W'(hi[1] * size);
    s2_b_q[0] <= ADDR_W'(lo[2] * size_sq);
    s2_b_q[1] <= ADDR_W'(hi[2] * size_sq);
  end

  // corner addresses; bit 0 red high, bit 1 green high, bit 2 blue high
  logic [7:0][ADDR_W-1:0] addr;
  logic                   wr_en;
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      addr[c] = ADDR_W'(s2_r_q[c % 2] + s2_g_q[(c / 2) % 2] + s2_b_q[c / 4]);
    end
  end
  assign wr_en = s2_valid_q && s2_write_q && (s2_idx_q < ADDR_W'(TABLE_DEPTH));

  // one table copy per corner so all eight are read at once
  for (genvar c = 0; c < 8; c++) begin : g_bank
    lut3d_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en),
      .waddr_i(s2_idx_q),
      .wdata_i(s2_data_q),
      .raddr_i(addr[c]),
      .rdata_o(corner_o[c])
    );
  end

  // stage 3: context aligned with read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_o <= 1'b0;
    end else begin
      rd_valid_o <= s2_valid_q && !s2_write_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ctx_o <= s2_ctx_q;
  end

endmodule
`default_nettype wire

// ===== src/lut3d_back.sv =====
// Back end: trilinear blend of the eight corners in three lerp stages
// (red, green, blue). Uses lut3d_pkg.
`default_nettype none
module lut3d_back
  import lut3d_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    rd_valid_i,
  input  wire samp_t                   rd_ctx_i,
  input  wire logic [7:0][ENTRY_W-1:0] corner_i,
  output logic                         res_valid_o,
  output logic      [2:0][IO_W-1:0]    res_o
);

  // stage A: four lerps along red per channel
  logic                       sa_valid_q;
  samp_t                      sa_ctx_q;
  logic [2:0][3:0][CH_W-1:0]  sa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_valid_q <= 1'b0;
    end else begin
      sa_valid_q <= rd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_ctx_q <= rd_ctx_i;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 4; j++) begin
        sa_q[k][j] <= lerp_fx(corner_i[2*j][k*CH_W +: CH_W],
                              corner_i[2*j+1][k*CH_W +: CH_W], rd_ctx_i.frac[0]);
      end
    end
  end

  // stage B: two lerps along green
  logic                       sb_valid_q;
  samp_t                      sb_ctx_q;
  logic [2:0][1:0][CH_W-1:0]  sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_valid_q <= 1'b0;
    end else begin
      sb_valid_q <= sa_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sb_ctx_q <= sa_ctx_q;
    for (int k = 0; k < 3; k++) begin
      sb_q[k][0] <= lerp_fx(sa_q[k][0], sa_q[k][1], sa_ctx_q.frac[1]);
      sb_q[k][1] <= lerp_fx(sa_q[k][2], sa_q[k][3], sa_ctx_q.frac[1]);
    end
  end

  // stage C: final lerp along blue, or raw pass-through
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (sb_ctx_q.pass) begin
        res_o[k] = sb_ctx_q.raw[k];
      end else begin
        res_o[k] = {1'b0, lerp_fx(sb_q[k][0], sb_q[k][1], sb_ctx_q.frac[2])};
      end
    end
  end
  assign res_valid_o = sb_valid_q;

endmodule
`default_nettype wire

// ===== src/lut3d_fifo.sv =====
// Result queue between the blend pipeline and the output channel.
// Show-ahead FIFO; uses lut3d_pkg.
`default_nettype none
module lut3d_fifo
  import lut3d_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire logic [2:0][IO_W-1:0]   push_data_i,
  input  wire logic                   pop_i,
  output logic                        valid_o,
  output logic      [2:0][IO_W-1:0]   data_o
);

  logic [2:0][IO_W-1:0] mem_q [QDEPTH];
  logic [QPTR_W-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  // pointer and fill update
  always_comb begin
    wr_d  = push_i ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = pop_i ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

endmodule
`default_nettype wire

// ===== src/lut3d_checker.sv =====
// Port-level checker for the 3D LUT color map, bound to the top level.
// Depends on lut3d_trilinear_color_map ports only.
`default_nettype none
module lut3d_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        cmd_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [17:0] red_out_o,
  input wire logic [17:0] green_out_o,
  input wire logic [17:0] blue_out_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_out_o)
      && $stable(green_out_o) && $stable(blue_out_o))
    else $error("stalled result changed");

  // nothing offered during reset
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid in reset");

  // an empty queue fills only from an earlier accepted sample
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && cmd_i, 6))
    else $error("result without matching sample");

endmodule

bind lut3d_trilinear_color_map lut3d_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .cmd_i      (cmd_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .red_out_o  (red_out_o),
  .green_out_o(green_out_o),
  .blue_out_o (blue_out_o)
);
`default_nettype wire

// ===== tb/lut3d_color_checker.sv =====
// Checker for the 3D LUT color map: watches both channels, predicts every
// sample through its own copy of the table, and compares results in order.
// Depends on lut3d_pkg.
`timescale 1ns / 1ps
module lut3d_color_checker
  import lut3d_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [SIZE_W-1:0]      cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_o,
  input  logic                   cmd_i,
  input  logic [15:0]            entry_index_i,
  input  logic signed [IO_W-1:0] red_in_i,
  input  logic signed [IO_W-1:0] green_in_i,
  input  logic signed [IO_W-1:0] blue_in_i,
  input  logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  logic signed [IO_W-1:0] red_out_o,
  input  logic signed [IO_W-1:0] green_out_o,
  input  logic signed [IO_W-1:0] blue_out_o,
  output int                     fail_count,
  output int                     pending_count,
  output int                     result_count
);

  typedef struct packed {
    logic [IO_W-1:0] r;
    logic [IO_W-1:0] g;
    logic [IO_W-1:0] b;
  } color_t;

  logic [CH_W-1:0] shadow_table [TABLE_DEPTH][3];
  logic [SIZE_W-1:0] grid_size;
  color_t expected_colors[$];

  function automatic logic [CH_W-1:0] sat_unit(input logic signed [IO_W-1:0] v);
    if (v <= 0) return '0;
    if (v >= ONE_FX) return CH_W'(ONE_FX);
    return CH_W'(v);
  endfunction

  // a + floor(((b - a) * t + 32768) / 65536)
  function automatic longint blend(input longint a, input longint b, input longint t);
    longint x;
    x = (b - a) * t + 32768;
    return a + (x >>> 16);
  endfunction

  function automatic color_t map_color(input logic signed [IO_W-1:0] ri,
                                       input logic signed [IO_W-1:0] gi,
                                       input logic signed [IO_W-1:0] bi);
    int unsigned sz, lo[3], hi[3], idx[8];
    longint fr[3], pos, v[8], res[3];
    logic signed [IO_W-1:0] ch[3];
    color_t c;
    ch[0] = ri; ch[1] = gi; ch[2] = bi;
    if (grid_size == 0) begin
      c.r = ri; c.g = gi; c.b = bi;
      return c;
    end
    sz = (grid_size > MAX_SIZE) ? MAX_SIZE : grid_size;
    for (int k = 0; k < 3; k++) begin
      pos = longint'(sat_unit(ch[k])) * (sz - 1);
      lo[k] = 32'(pos >> 16);
      fr[k] = pos & 16'hFFFF;
      hi[k] = (lo[k] + 1 < sz) ? lo[k] + 1 : lo[k];
    end
    // corner bit 0 picks red high, bit 1 green high, bit 2 blue high
    for (int n = 0; n < 8; n++) begin
      idx[n] = (n[0] ? hi[0] : lo[0]) + (n[1] ? hi[1] : lo[1]) * sz
             + (n[2] ? hi[2] : lo[2]) * sz * sz;
      if (idx[n] >= TABLE_DEPTH) idx[n] = 0;
    end
    for (int k = 0; k < 3; k++) begin
      for (int n = 0; n < 8; n++) v[n] = shadow_table[idx[n]][k];
      res[k] = blend(blend(blend(v[0], v[1], fr[0]), blend(v[2], v[3], fr[0]), fr[1]),
                     blend(blend(v[4], v[5], fr[0]), blend(v[6], v[7], fr[0]), fr[1]),
                     fr[2]);
    end
    c.r = IO_W'(res[0]); c.g = IO_W'(res[1]); c.b = IO_W'(res[2]);
    return c;
  endfunction

  assign pending_count = expected_colors.size();

  always @(posedge clk_i or negedge rst_ni) begin
    color_t want, got;
    if (!rst_ni) begin
      grid_size <= '0;
      fail_count <= 0;
      result_count <= 0;
      expected_colors.delete();
    end else begin
      if (cfg_we_i) grid_size <= cfg_data_i;
      // input transaction
      if (in_valid_i && !in_stall_o) begin
        if (cmd_i == CMD_WRITE) begin
          if (entry_index_i < TABLE_DEPTH) begin
            shadow_table[entry_index_i][0] = sat_unit(red_in_i);
            shadow_table[entry_index_i][1] = sat_unit(green_in_i);
            shadow_table[entry_index_i][2] = sat_unit(blue_in_i);
          end
        end else begin
          expected_colors.insert(expected_colors.size(),
                                 map_color(red_in_i, green_in_i, blue_in_i));
        end
      end
      // output transaction
      if (out_valid_o && !out_stall_i) begin
        got.r = red_out_o; got.g = green_out_o; got.b = blue_out_o;
        result_count <= result_count + 1;
        if (expected_colors.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_colors.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display("mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                       want.r, want.g, want.b, got.r, got.g, got.b);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/lut3d_trilinear_color_map_test.sv =====
// Testbench top for the 3D LUT color map: drives writes, samples and size
// changes with random gaps and stalls. Depends on lut3d_pkg, the color map and the checker.
`timescale 1ns / 1ps
module lut3d_trilinear_color_map_test;
  import lut3d_pkg::*;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [SIZE_W-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o, cmd_i;
  logic [15:0] entry_index_i;
  logic signed [IO_W-1:0] red_in_i, green_in_i, blue_in_i;
  logic out_valid_o, out_stall_i;
  logic signed [IO_W-1:0] red_out_o, green_out_o, blue_out_o;
  int fail_count, pending_count, result_count;
  int sample_count;
  bit long_hold;

  lut3d_trilinear_color_map uut (.*);
  lut3d_color_checker checker_inst (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [IO_W-1:0] rand_chan();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return IO_W'($urandom);
    if (r == 1) return IO_W'(ONE_FX + $urandom_range(0, 3));
    if (r == 2) return IO_W'(-$urandom_range(0, 3));
    return IO_W'($urandom_range(0, ONE_FX));
  endfunction

  // channel near either end of the unit range; on the full-size cube it
  // only touches the two lowest and the two highest grid points of an axis
  function automatic logic signed [IO_W-1:0] end_chan();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return IO_W'(-$urandom_range(1, 131072));
    if (r == 1) return IO_W'(ONE_FX + $urandom_range(0, 3));
    if (r < 6) return IO_W'($urandom_range(0, ONE_FX / (MAX_SIZE - 1) - 1));
    return IO_W'($urandom_range((MAX_SIZE - 2) * ONE_FX / (MAX_SIZE - 1), ONE_FX));
  endfunction

  // receiver stalls; one long hold-off while the sender keeps offering
  initial begin
    out_stall_i = 0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_stall_i <= 1;
        repeat (200) @(posedge clk_i);
        long_hold = 0;
      end
      out_stall_i <= ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      if ($urandom_range(0, 40) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end
    end
  end

  // one input transaction, held until accepted
  task automatic send(input logic cmd, input logic [15:0] index,
                      input logic signed [IO_W-1:0] r, g, b, input bit gaps);
    int g_len;
    g_len = gaps ? gap_len() : 0;
    if (g_len > 0) begin
      in_valid_i <= 0;
      repeat (g_len) @(posedge clk_i);
    end
    in_valid_i <= 1;
    cmd_i <= cmd;
    entry_index_i <= index;
    red_in_i <= r; green_in_i <= g; blue_in_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (cmd == CMD_SAMPLE) sample_count++;
  endtask

  task automatic drain_and_set(input logic [SIZE_W-1:0] size);
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_data_i <= size;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // fill the whole cube in use so that no unwritten entry is ever read
  task automatic fill_table(input int sz, input bit gaps);
    for (int i = 0; i < sz * sz * sz; i++)
      send(CMD_WRITE, 16'(i), rand_chan(), rand_chan(), rand_chan(), gaps);
  endtask

  // full-size cube: write the grid points that end_chan samples can reach
  task automatic fill_ends();
    int pts[4] = '{0, 1, MAX_SIZE - 2, MAX_SIZE - 1};
    foreach (pts[b])
      foreach (pts[g])
        foreach (pts[r])
          send(CMD_WRITE, 16'(pts[r] + pts[g] * MAX_SIZE + pts[b] * MAX_SIZE * MAX_SIZE),
               rand_chan(), rand_chan(), rand_chan(), 1'b1);
  endtask

  task automatic random_samples(input int n, input bit ends);
    logic signed [IO_W-1:0] r, g, b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send(CMD_WRITE, 16'($urandom), rand_chan(), rand_chan(), rand_chan(), 1'b1);
      end else begin
        r = ends ? end_chan() : rand_chan();
        g = ends ? end_chan() : rand_chan();
        b = ends ? end_chan() : rand_chan();
        send(CMD_SAMPLE, 16'($urandom), r, g, b, 1'b1);
      end
    end
  endtask

  initial begin
    int sizes[6] = '{2, 5, 1, 3, 33, 63};
    int sz;
    rst_ni = 0;
    cfg_we_i = 0; cfg_data_i = 0;
    in_valid_i = 0; cmd_i = 0; entry_index_i = 0;
    red_in_i = 0; green_in_i = 0; blue_in_i = 0;
    sample_count = 0;
    long_hold = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // pass-through with size zero: extremes of the raw channels
    send(CMD_SAMPLE, 16'hFFFF, 18'sh1FFFF, 18'sh20000, 18'sd0, 1'b0);
    send(CMD_SAMPLE, 16'd0, -18'sd1, 18'sd65536, 18'sh2AAAA, 1'b0);
    send(CMD_WRITE, 16'hFFFF, 18'sh1FFFF, 18'sh20000, 18'sd0, 1'b0);   // index beyond table
    send(CMD_WRITE, 16'(TABLE_DEPTH), 18'sd65536, 18'sd0, 18'sd1, 1'b0);
    random_samples(40, 1'b0);

    // directed on a size-2 cube: corners, clamp, write saturation
    drain_and_set(6'd2);
    fill_table(2, 1'b0);
    send(CMD_WRITE, 16'd7, 18'sh1FFFF, 18'sh20000, 18'sd65537, 1'b0);
    send(CMD_SAMPLE, 16'd0, 18'sd0, 18'sd0, 18'sd0, 1'b0);
    send(CMD_SAMPLE, 16'd0, 18'sd65536, 18'sd65536, 18'sd65536, 1'b0);
    send(CMD_SAMPLE, 16'd0, 18'sh1FFFF, 18'sh20000, 18'sd32768, 1'b0);
    send(CMD_SAMPLE, 16'd0, 18'sd65535, 18'sd1, 18'sd32767, 1'b0);

    foreach (sizes[s]) begin
      sz = (sizes[s] > MAX_SIZE) ? MAX_SIZE : sizes[s];
      drain_and_set(6'(sizes[s]));
      // the full-size cube is written at its ends once and reused above MAX_SIZE
      if (sizes[s] == MAX_SIZE) fill_ends();
      else if (sizes[s] < MAX_SIZE) fill_table(sz, 1'b1);
      if (s == 1) long_hold = 1;
      random_samples(sz == MAX_SIZE ? 60 : 90, sz == MAX_SIZE);
    end

    drain_and_set(6'd0);
    random_samples(30, 1'b0);

    in_valid_i <= 0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d samples over table sizes 0 to 63 with random stalls;",
             sample_count);
    $display("%0d results checked.", result_count);
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lut3d_pkg.sv
src/lut3d_ram.sv
src/lut3d_front.sv
src/lut3d_back.sv
src/lut3d_fifo.sv
src/lut3d_trilinear_color_map.sv
src/lut3d_checker.sv
tb/lut3d_color_checker.sv
tb/lut3d_trilinear_color_map_test.sv
